// ===== src/wfs_pkg.sv =====
// ----------------------------------------------------------------------------
// wfs_pkg
// shared types, codes and constants of the window filter similarity core
// ----------------------------------------------------------------------------
package wfs_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int WEIGHT_W  = 17;
    localparam int SCORE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int NORM_W    = 17;
    localparam int ROOT_W    = 17;
    localparam int PROD_W    = 36;
    localparam int S_W       = 17;
    localparam int D_W       = 21;
    localparam int P_W       = 31;
    localparam int X_W       = 30;
    localparam int DEN_W     = 32;
    localparam int ONE_Q16   = 65536;
    localparam int HALF_Q16  = 32768;
    localparam int NORM_STEPS = 17;
    localparam int SQ_STEPS  = 17;
    localparam int POLY_ORDER = 12;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FLAT     = 2'd1,
        STATUS_SHORT    = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_RD,
        S_RDW,
        S_DIV,
        S_SQI,
        S_SQ,
        S_ACC,
        S_SDIV,
        S_SWAIT,
        S_DDIV,
        S_DWAIT,
        S_SQR,
        S_T,
        S_PM,
        S_PD,
        S_PWAIT,
        S_POW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic in_take;
        logic norm_flat;
        logic div_norm;
        logic norm_take;
        logic sq_start;
        logic acc;
        logic div_s;
        logic s_take;
        logic div_d;
        logic d_take;
        logic sqr;
        logic t_take;
        logic pm;
        logic div_p;
        logic p_take;
        logic pow_step;
        logic out_load;
    } wfs_cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic flat;
        logic div_busy;
        logic sq_busy;
        logic idx_last;
        logic t_big;
        logic k_last;
        logic ip_zero;
    } wfs_sts_t;

    // exp(-1) by the degree-12 taylor polynomial, q.30, worked out at elaboration
    function automatic logic [P_W-1:0] exp_poly_one();
        logic [63:0] one;
        logic [63:0] p;
        one = 64'd1 << 30;
        p   = one;
        for (int k = POLY_ORDER; k >= 1; k--) begin
            p = one - ((one * p) >> 30) / 64'(k);
        end
        return p[P_W-1:0];
    endfunction

    localparam logic [P_W-1:0] EXP_ONE_Q30 = exp_poly_one();
    localparam logic [P_W-1:0] ONE_Q30     = P_W'(1) << 30;

endpackage

// ===== src/wfs_ram.sv =====
// ----------------------------------------------------------------------------
// wfs_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module wfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/wfs_div.sv =====
// ----------------------------------------------------------------------------
// wfs_div
// restoring divider, one quotient bit per cycle, variable step count
// ----------------------------------------------------------------------------
module wfs_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 32,
    parameter int STEP_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [NUM_W-1:0]  num_init,
    input  logic [DEN_W-1:0]  den,
    input  logic [STEP_W-1:0] steps,
    output logic              busy,
    output logic [NUM_W-1:0]  quot
);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next  = rem_init;
            num_next  = num_init;
            quot_next = '0;
            den_next  = den;
            cnt_next  = steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[NUM_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

// ===== src/wfs_dp.sv =====
// ----------------------------------------------------------------------------
// wfs_dp
// window storage, normalize and accumulate datapath, exp evaluation
// ----------------------------------------------------------------------------
module wfs_dp import wfs_pkg::*; #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wfs_cmd_t            cmd,
    output wfs_sts_t            sts,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [WEIGHT_W-1:0] weight,
    output logic [SCORE_W-1:0]  score,
    output logic [STATUS_W-1:0] status
);

    localparam int CW     = $clog2(MAX_WINDOW + 1);
    localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM1_W = ROOT_W + CW;
    localparam int SUM2_W = PROD_W + CW;
    localparam int QW     = (SUM2_W > 48) ? SUM2_W : 48;
    localparam int STEP_W = $clog2(QW + 1);
    localparam logic [QW-1:0] S_OFFSET = QW'(ONE_Q16);
    localparam logic [QW-1:0] D_OFFSET = QW'(64'h1_0000_0000);

    // load side
    logic [CW-1:0]       fill_reg, fill_next;
    logic                ovf_reg, ovf_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [WEIGHT_W-1:0] w_clamp;
    logic                full;
    logic                ram_we;
    logic [SAMPLE_W-1:0] sample_rd;
    logic [WEIGHT_W-1:0] weight_rd;

    // per sample pass
    logic [CW-1:0]       idx_reg;
    logic [NORM_W-1:0]   norm_reg, prev_norm_reg;
    logic [WEIGHT_W-1:0] prev_w_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SUM1_W-1:0]   sum1_reg;
    logic [SUM2_W-1:0]   sum2_reg;
    logic [SAMPLE_W:0]   off_w;
    logic [SAMPLE_W:0]   range_w;
    logic [NORM_W-1:0]   absdiff;
    logic [18:0]         dn, dw, g;
    logic [17:0]         gabs, q;

    // integer square root
    logic [33:0]         sq_num_reg;
    logic [19:0]         sq_rem_reg;
    logic [ROOT_W-1:0]   sq_root_reg;
    logic [4:0]          sq_cnt_reg;
    logic [19:0]         sq_r4, sq_trial;
    logic                sq_ge;

    // divider
    logic                div_start;
    logic [DEN_W-1:0]    div_rem;
    logic [QW-1:0]       div_num;
    logic [DEN_W-1:0]    div_den;
    logic [STEP_W-1:0]   div_steps;
    logic                div_busy;
    logic [QW-1:0]       quot;
    logic [QW-1:0]       dsub;

    // score
    logic [S_W-1:0]      s_reg;
    logic [D_W-1:0]      d_reg;
    logic [2*S_W-1:0]    ss_reg;
    logic [2*D_W-1:0]    dd_reg;
    logic [2*D_W:0]      tsum;
    logic [26:0]         t_val;
    logic [X_W-1:0]      x_reg;
    logic [P_W-1:0]      p_reg;
    logic [P_W-1:0]      mp_reg;
    logic [3:0]          k_reg;
    logic [3:0]          ip_reg;
    logic [X_W+P_W-1:0]  xp;
    logic [2*P_W-1:0]    pe;
    logic [16:0]         ep;
    logic [SCORE_W-1:0]  score_reg;
    logic [STATUS_W-1:0] status_reg;

    // window capture
    always_comb
    begin
        w_clamp  = (weight > WEIGHT_W'(ONE_Q16)) ? WEIGHT_W'(ONE_Q16) : weight;
        full     = (fill_reg == CW'(MAX_WINDOW));
        ram_we   = cmd.in_take && !full;
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        if (cmd.in_take)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
                if (fill_reg == '0)
                begin
                    min_next = sample;
                    max_next = sample;
                end
                else
                begin
                    if ($signed(sample) > $signed(max_reg))
                    begin
                        max_next = sample;
                    end
                    if ($signed(sample) < $signed(min_reg))
                    begin
                        min_next = sample;
                    end
                end
            end
        end
        if (cmd.out_load)
        begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end
    end

    wfs_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (sample),
        .raddr (idx_reg[AW-1:0]),
        .rdata (sample_rd)
    );

    wfs_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_WINDOW)) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (w_clamp),
        .raddr (idx_reg[AW-1:0]),
        .rdata (weight_rd)
    );

    // normalize operands, step difference, sqrt step
    always_comb
    begin
        off_w   = {sample_rd[SAMPLE_W-1], sample_rd} - {min_reg[SAMPLE_W-1], min_reg};
        range_w = {max_reg[SAMPLE_W-1], max_reg} - {min_reg[SAMPLE_W-1], min_reg};
        absdiff = (norm_reg >= weight_rd) ? (norm_reg - weight_rd) : (weight_rd - norm_reg);
        dn      = {2'b00, norm_reg} - {2'b00, prev_norm_reg};
        dw      = {2'b00, weight_rd} - {2'b00, prev_w_reg};
        g       = dn - dw;
        gabs    = g[18] ? 18'(-g) : g[17:0];
        q       = gabs + 18'(ONE_Q16);
        sq_r4    = {sq_rem_reg[17:0], sq_num_reg[33:32]};
        sq_trial = {1'b0, sq_root_reg, 2'b01};
        sq_ge    = (sq_r4 >= sq_trial);
    end

    // shared divider operand select
    always_comb
    begin
        div_start = cmd.div_norm || cmd.div_s || cmd.div_d || cmd.div_p;
        div_rem   = '0;
        div_num   = '0;
        div_den   = '0;
        div_steps = STEP_W'(QW);
        if (cmd.div_norm)
        begin
            div_rem   = {1'b0, off_w[SAMPLE_W-1:1]};
            div_num   = {off_w[0], {(QW-1){1'b0}}};
            div_den   = range_w[SAMPLE_W-1:0];
            div_steps = STEP_W'(NORM_STEPS);
        end
        else if (cmd.div_s)
        begin
            div_num = QW'(sum1_reg);
            div_den = DEN_W'(fill_reg);
        end
        else if (cmd.div_d)
        begin
            div_num = QW'(sum2_reg);
            div_den = DEN_W'(fill_reg - 1'b1);
        end
        else if (cmd.div_p)
        begin
            div_num = QW'(mp_reg);
            div_den = DEN_W'(k_reg);
        end
    end

    wfs_div #(.NUM_W(QW), .DEN_W(DEN_W), .STEP_W(STEP_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .num_init (div_num),
        .den      (div_den),
        .steps    (div_steps),
        .busy     (div_busy),
        .quot     (quot)
    );

    // score path
    always_comb
    begin
        dsub  = quot - D_OFFSET;
        tsum  = {{(2*D_W-2*S_W+1){1'b0}}, ss_reg} + {1'b0, dd_reg};
        t_val = tsum[42:16];
        xp    = {{P_W{1'b0}}, x_reg} * {{X_W{1'b0}}, p_reg};
        pe    = {{P_W{1'b0}}, p_reg} * {{P_W{1'b0}}, EXP_ONE_Q30};
        ep    = p_reg[P_W-1:14];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            idx_reg    <= '0;
            sq_cnt_reg <= '0;
            sum1_reg   <= '0;
            sum2_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
            if (cmd.sq_start)
            begin
                sq_cnt_reg <= 5'(SQ_STEPS);
            end
            else if (sq_cnt_reg != '0)
            begin
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                idx_reg  <= '0;
                sum1_reg <= '0;
                sum2_reg <= '0;
            end
            else if (cmd.acc)
            begin
                idx_reg  <= idx_reg + 1'b1;
                sum1_reg <= sum1_reg + SUM1_W'(sq_root_reg);
                if (idx_reg != '0)
                begin
                    sum2_reg <= sum2_reg + SUM2_W'(prod_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        if (cmd.norm_flat)
        begin
            norm_reg <= NORM_W'(HALF_Q16);
        end
        else if (cmd.norm_take)
        begin
            norm_reg <= quot[NORM_W-1:0];
        end
        if (cmd.sq_start)
        begin
            sq_num_reg  <= {absdiff + 18'(ONE_Q16), 16'h0000};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            prod_reg    <= {18'd0, q} * {18'd0, q};
        end
        else if (sq_cnt_reg != '0)
        begin
            sq_num_reg  <= {sq_num_reg[31:0], 2'b00};
            sq_rem_reg  <= sq_ge ? (sq_r4 - sq_trial) : sq_r4;
            sq_root_reg <= {sq_root_reg[ROOT_W-2:0], sq_ge};
        end
        if (cmd.acc)
        begin
            prev_norm_reg <= norm_reg;
            prev_w_reg    <= weight_rd;
        end
        if (cmd.s_take)
        begin
            s_reg <= (quot > S_OFFSET) ? S_W'(quot - S_OFFSET) : '0;
        end
        if (cmd.d_take)
        begin
            d_reg <= (quot > D_OFFSET) ? dsub[16+D_W-1:16] : '0;
        end
        if (cmd.sqr)
        begin
            ss_reg <= {{S_W{1'b0}}, s_reg} * {{S_W{1'b0}}, s_reg};
            dd_reg <= {{D_W{1'b0}}, d_reg} * {{D_W{1'b0}}, d_reg};
        end
        if (cmd.t_take)
        begin
            if (sts.t_big)
            begin
                p_reg  <= '0;
                ip_reg <= '0;
            end
            else
            begin
                p_reg  <= ONE_Q30;
                x_reg  <= {t_val[15:0], 14'h0000};
                ip_reg <= t_val[19:16];
                k_reg  <= 4'(POLY_ORDER);
            end
        end
        if (cmd.pm)
        begin
            mp_reg <= xp[X_W+P_W-1:30];
        end
        if (cmd.p_take)
        begin
            p_reg <= ONE_Q30 - quot[P_W-1:0];
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.pow_step)
        begin
            p_reg  <= pe[P_W+29:30];
            ip_reg <= ip_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            if (fill_reg < CW'(2))
            begin
                score_reg  <= '0;
                status_reg <= STATUS_SHORT;
            end
            else
            begin
                // top of range saturates, otherwise remove the half offset
                score_reg  <= ep[16] ? {1'b0, {(SCORE_W-1){1'b1}}} : {~ep[15], ep[14:0]};
                status_reg <= ovf_reg ? STATUS_OVERFLOW
                            : ((min_reg == max_reg) ? STATUS_FLAT : STATUS_OK);
            end
        end
    end

    always_comb
    begin
        sts.fill_zero = (fill_reg == '0);
        sts.flat      = (min_reg == max_reg);
        sts.div_busy  = div_busy;
        sts.sq_busy   = (sq_cnt_reg != '0);
        sts.idx_last  = (idx_reg == fill_reg - 1'b1);
        sts.t_big     = |t_val[26:20];
        sts.k_last    = (k_reg == 4'd1);
        sts.ip_zero   = (ip_reg == '0);
    end

    assign score  = score_reg;
    assign status = status_reg;

endmodule

// ===== src/wfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfs_ctrl
// sequencer for window load, per sample pass and score evaluation
// ----------------------------------------------------------------------------
module wfs_ctrl import wfs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     last,
    output logic     out_valid,
    input  logic     out_ready,
    input  wfs_sts_t sts,
    output wfs_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;
    logic   out_free;

    assign take     = in_valid && (state_reg == S_LOAD);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:  if (take && last) state_next = sts.fill_zero ? S_OUT : S_RD;
            S_RD:    state_next = S_RDW;
            S_RDW:   state_next = sts.flat ? S_SQI : S_DIV;
            S_DIV:   if (!sts.div_busy) state_next = S_SQI;
            S_SQI:   state_next = S_SQ;
            S_SQ:    if (!sts.sq_busy) state_next = S_ACC;
            S_ACC:   state_next = sts.idx_last ? S_SDIV : S_RD;
            S_SDIV:  state_next = S_SWAIT;
            S_SWAIT: if (!sts.div_busy) state_next = S_DDIV;
            S_DDIV:  state_next = S_DWAIT;
            S_DWAIT: if (!sts.div_busy) state_next = S_SQR;
            S_SQR:   state_next = S_T;
            S_T:     state_next = sts.t_big ? S_POW : S_PM;
            S_PM:    state_next = S_PD;
            S_PD:    state_next = S_PWAIT;
            S_PWAIT: if (!sts.div_busy) state_next = sts.k_last ? S_POW : S_PM;
            S_POW:   if (sts.ip_zero) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_LOAD;
            default: state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_LOAD:  cmd.in_take   = take;
            S_RDW:
            begin
                cmd.norm_flat = sts.flat;
                cmd.div_norm  = !sts.flat;
            end
            S_DIV:   cmd.norm_take = !sts.div_busy;
            S_SQI:   cmd.sq_start  = 1'b1;
            S_ACC:   cmd.acc       = 1'b1;
            S_SDIV:  cmd.div_s     = 1'b1;
            S_SWAIT: cmd.s_take    = !sts.div_busy;
            S_DDIV:  cmd.div_d     = 1'b1;
            S_DWAIT: cmd.d_take    = !sts.div_busy;
            S_SQR:   cmd.sqr       = 1'b1;
            S_T:     cmd.t_take    = 1'b1;
            S_PM:    cmd.pm        = 1'b1;
            S_PD:    cmd.div_p     = 1'b1;
            S_PWAIT: cmd.p_take    = !sts.div_busy;
            S_POW:   cmd.pow_step  = !sts.ip_zero;
            S_OUT:   cmd.out_load  = out_free;
            default: cmd = '0;
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/window_filter_similarity_core.sv =====
// ----------------------------------------------------------------------------
// window_filter_similarity_core
// loads one item per cycle while loading; after the item marked last each
// sample is normalized (no divide in a flat window), square rooted and summed;
// then the means, then exp with a power step per whole unit of its argument; a
// one-item window skips the walk; each result waits in an output register
// reset clears the sequencer, fill count, overflow flag and output valid
// ----------------------------------------------------------------------------
module window_filter_similarity_core import wfs_pkg::*; #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SCORE_W-1:0]  score,
    output logic [STATUS_W-1:0] status
);

    // command and status between sequencer and datapath
    wfs_cmd_t cmd;
    wfs_sts_t sts;

    // sequencer: load, per sample walk, means, exp, result hand off
    wfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: window rams, min/max, divider, square root, exp, output register
    wfs_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .sample (sample),
        .weight (weight),
        .score  (score),
        .status (status)
    );

`ifndef ASSERT_OFF
    // no item is taken while an iterative unit is still running
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!sts.div_busy && !sts.sq_busy))
        else $error("item accepted while divider or sqrt busy");

    // a short window always reports a zero score
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == 2'(STATUS_SHORT)) |-> (score == '0))
        else $error("short window with nonzero score");

    // loading the output register raises valid on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result loaded without valid");
`endif

endmodule
